// File: rtl/rftm_pkg.sv
// Shared types, widths and constants of the rise/fall time meter.
`timescale 1ns / 1ps
package rftm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 16;
  localparam int RATIO_W    = 17;
  localparam int RATE_W     = 27;
  localparam int INDEX_W    = 20;
  localparam int FRAC_W     = 16;
  localparam int COUNT_W    = 20;
  localparam int TOTAL_W    = 40;
  localparam int TIME_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int THR_W  = 36;                  // threshold, 16 fraction bits
  localparam int NUM_W  = THR_W;
  localparam int DEN_W  = SAMPLE_W + 1 + FRAC_W;
  localparam int POS_W  = INDEX_W + FRAC_W + 1; // room for a full fraction on max index
  localparam int NS_W   = 30;
  localparam int HALF_W = TOTAL_W / 2;
  localparam int PROD_W = TOTAL_W + NS_W;
  localparam int DIVD_W = PROD_W - FRAC_W;
  localparam int CSUM_W = COUNT_W + RATE_W;
  localparam int ITER_W = 6;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  localparam logic [RATIO_W-1:0]  ONE_RATIO = RATIO_W'(65536);
  localparam logic [FRAC_W:0]     ONE_FRAC  = {1'b1, {FRAC_W{1'b0}}};
  localparam logic [NS_W-1:0]     NS_SCALE  = NS_W'(1000000000);
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_EDGES = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_LEVEL, CFG_HIGH_LEVEL, CFG_LOW_RATIO, CFG_HIGH_RATIO, CFG_SAMPLE_RATE
  } cfg_index_t;

  typedef enum logic [1:0] {MODE_IDLE, MODE_RISE, MODE_FALL} edge_mode_t;

  typedef enum logic [2:0] {
    EV_NONE, EV_OPEN_RISE, EV_OPEN_FALL, EV_CLOSE_RISE, EV_CLOSE_FALL
  } event_t;

  typedef enum logic [3:0] {
    B_IDLE, B_PREP, B_FRAC, B_APPLY, B_END, B_MLO, B_MHI, B_MINIT, B_MDIV, B_MDONE, B_OUT
  } back_state_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] low_level;
    logic signed [LEVEL_W-1:0] high_level;
    logic [RATIO_W-1:0]        lo_frac;
    logic [RATIO_W-1:0]        hi_frac;
    logic [RATE_W-1:0]         rate;
  } cfg_t;

  // one crossing or frame end request from front to back
  typedef struct packed {
    event_t                  ev;
    logic [INDEX_W-1:0]      idx;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
    logic                    last;
    logic                    enough;
  } job_t;

endpackage

// File: rtl/rftm_sample_if.sv
// Sample stream channel.
`timescale 1ns / 1ps
interface rftm_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rftm_pkg::SAMPLE_W-1:0] sample;
  logic                                 last;
  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

// File: rtl/rftm_result_if.sv
// Result stream channel.
`timescale 1ns / 1ps
interface rftm_result_if;
  logic                          valid;
  logic                          ready;
  logic [rftm_pkg::STATUS_W-1:0] status;
  logic [rftm_pkg::TIME_W-1:0]   rise_time_ns;
  logic [rftm_pkg::TIME_W-1:0]   fall_time_ns;
  logic [rftm_pkg::COUNT_W-1:0]  rise_num;
  logic [rftm_pkg::COUNT_W-1:0]  fall_num;
  modport source (output valid, output status, output rise_time_ns, output fall_time_ns,
                  output rise_num, output fall_num, input ready);
  modport sink (input valid, input status, input rise_time_ns, input fall_time_ns,
                input rise_num, input fall_num, output ready);
endinterface

// File: rtl/rftm_cfg_if.sv
// Configuration write channel.
`timescale 1ns / 1ps
interface rftm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rftm_pkg::CFG_IDX_W-1:0]  index;
  logic [rftm_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/rise_fall_time_meter.sv
// Top level of the rise/fall time meter: configuration registers and front/back hookup.
`timescale 1ns / 1ps
// Measures mean 10/90-style rise and fall times over framed signed samples. The front end
// takes one sample per cycle as long as its four-entry request queue has room; a sample is
// held off in the cycle after each register write while the thresholds reload. Each sample
// that opens or closes an edge, and each frame-end sample, becomes one queued request. The
// back end takes a crossing through its prep and apply states, with a 16-step restoring
// divider between them when it needs interpolation, so back-to-back crossings throttle the
// stream. At frame end, with a valid configuration, the rise and fall means run in turn
// through the shared 54-step mean divider; the result then waits in its output register
// until taken while the next frame's samples keep queuing. No clearing pass follows reset.
module rise_fall_time_meter (
  input logic           clk,
  input logic           rst,
  rftm_sample_if.sink   samples,
  rftm_result_if.source results,
  rftm_cfg_if.sink      cfg
);

  rftm_pkg::cfg_t regs;
  rftm_pkg::job_t push_job, pop_job;
  logic push, pop, full, empty, cfg_wr;

  assign cfg.ready = 1'b1;
  assign cfg_wr = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.low_level  <= '0;
      regs.high_level <= rftm_pkg::LEVEL_W'(32767);
      regs.lo_frac    <= rftm_pkg::RATIO_W'(6554);
      regs.hi_frac    <= rftm_pkg::RATIO_W'(58982);
      regs.rate       <= rftm_pkg::RATE_W'(1000000);
    end else if (cfg_wr) begin
      unique case (cfg.index)
        rftm_pkg::CFG_LOW_LEVEL:   regs.low_level  <= cfg.data[rftm_pkg::LEVEL_W-1:0];
        rftm_pkg::CFG_HIGH_LEVEL:  regs.high_level <= cfg.data[rftm_pkg::LEVEL_W-1:0];
        rftm_pkg::CFG_LOW_RATIO:   regs.lo_frac    <= cfg.data[rftm_pkg::RATIO_W-1:0];
        rftm_pkg::CFG_HIGH_RATIO:  regs.hi_frac    <= cfg.data[rftm_pkg::RATIO_W-1:0];
        rftm_pkg::CFG_SAMPLE_RATE: regs.rate       <= cfg.data[rftm_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  rftm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .cfg      (regs),
    .cfg_wr   (cfg_wr),
    .push     (push),
    .push_job (push_job),
    .full     (full)
  );

  rftm_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  rftm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (regs),
    .empty   (empty),
    .pop_job (pop_job),
    .pop     (pop),
    .results (results)
  );

endmodule

// File: rtl/rftm_fifo.sv
// Short request queue between front and back.
`timescale 1ns / 1ps
module rftm_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rftm_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output rftm_pkg::job_t pop_job,
  output logic           empty
);

  rftm_pkg::job_t entries [rftm_pkg::Q_DEPTH];
  logic [rftm_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [rftm_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [rftm_pkg::Q_PTR_W:0]   count;

  assign full    = (count == (rftm_pkg::Q_PTR_W + 1)'(rftm_pkg::Q_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("request queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("request queue underflow");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (rftm_pkg::Q_PTR_W + 1)'(rftm_pkg::Q_DEPTH))
    else $error("request queue count out of range");

endmodule

// File: rtl/rftm_front.sv
// Front end: thresholds, crossing detection and edge mode tracking.
`timescale 1ns / 1ps
module rftm_front (
  input  logic              clk,
  input  logic              rst,
  rftm_sample_if.sink       samples,
  input  rftm_pkg::cfg_t    cfg,
  input  logic              cfg_wr,
  output logic              push,
  output rftm_pkg::job_t    push_job,
  input  logic              full
);

  rftm_pkg::edge_mode_t mode, mode_next;
  logic signed [rftm_pkg::SAMPLE_W-1:0] prev;
  logic [rftm_pkg::INDEX_W-1:0] index, index_inc;
  logic signed [rftm_pkg::THR_W-1:0] thr_lo, thr_hi, thr_lo_next, thr_hi_next, base;
  logic hold;

  logic signed [rftm_pkg::LEVEL_W:0] span;
  logic signed [2*rftm_pkg::LEVEL_W+2:0] lo_prod, hi_prod;
  logic signed [rftm_pkg::THR_W-1:0] a, b, thr_sel;
  logic accept;
  rftm_pkg::event_t ev;

  // thresholds are registered so the multiply ends on a flop
  assign span = $signed({cfg.high_level[rftm_pkg::LEVEL_W-1], cfg.high_level})
              - $signed({cfg.low_level[rftm_pkg::LEVEL_W-1], cfg.low_level});
  assign lo_prod = $signed({1'b0, cfg.lo_frac}) * span;
  assign hi_prod = $signed({1'b0, cfg.hi_frac}) * span;
  assign base = $signed({{4{cfg.low_level[rftm_pkg::LEVEL_W-1]}}, cfg.low_level,
                         {rftm_pkg::FRAC_W{1'b0}}});
  assign thr_lo_next = base + $signed({lo_prod[2*rftm_pkg::LEVEL_W+2], lo_prod});
  assign thr_hi_next = base + $signed({hi_prod[2*rftm_pkg::LEVEL_W+2], hi_prod});

  assign samples.ready = !full && !hold;
  assign accept = samples.valid && samples.ready;

  assign a = $signed({{4{prev[rftm_pkg::SAMPLE_W-1]}}, prev, {rftm_pkg::FRAC_W{1'b0}}});
  assign b = $signed({{4{samples.sample[rftm_pkg::SAMPLE_W-1]}}, samples.sample,
                      {rftm_pkg::FRAC_W{1'b0}}});
  assign index_inc = (index == '1) ? index : index + 1'b1;

  always_comb begin
    ev = rftm_pkg::EV_NONE;
    mode_next = mode;
    thr_sel = thr_lo;
    if (index != '0) begin
      unique case (mode)
        rftm_pkg::MODE_RISE: begin
          thr_sel = thr_hi;
          if (a < thr_hi && b >= thr_hi) begin
            ev = rftm_pkg::EV_CLOSE_RISE;
            mode_next = rftm_pkg::MODE_IDLE;
          end
        end
        rftm_pkg::MODE_FALL: begin
          if (a > thr_lo && b <= thr_lo) begin
            ev = rftm_pkg::EV_CLOSE_FALL;
            mode_next = rftm_pkg::MODE_IDLE;
          end
        end
        default: begin
          if (a < thr_lo && b >= thr_lo) begin
            ev = rftm_pkg::EV_OPEN_RISE;
            mode_next = rftm_pkg::MODE_RISE;
          end else if (a > thr_hi && b <= thr_hi) begin
            thr_sel = thr_hi;
            ev = rftm_pkg::EV_OPEN_FALL;
            mode_next = rftm_pkg::MODE_FALL;
          end
        end
      endcase
    end
    if (samples.last) mode_next = rftm_pkg::MODE_IDLE;
  end

  assign push = accept && (ev != rftm_pkg::EV_NONE || samples.last);
  assign push_job.ev     = ev;
  assign push_job.idx    = index - 1'b1;
  assign push_job.num    = thr_sel - a;
  assign push_job.den    = $signed({samples.sample[rftm_pkg::SAMPLE_W-1], samples.sample,
                                    {rftm_pkg::FRAC_W{1'b0}}})
                         - $signed({prev[rftm_pkg::SAMPLE_W-1], prev,
                                    {rftm_pkg::FRAC_W{1'b0}}});
  assign push_job.last   = samples.last;
  assign push_job.enough = (index_inc > rftm_pkg::INDEX_W'(1));

  always_ff @(posedge clk) begin
    thr_lo <= thr_lo_next;
    thr_hi <= thr_hi_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= rftm_pkg::MODE_IDLE;
      prev  <= '0;
      index <= '0;
      hold  <= 1'b1;
    end else begin
      // thresholds are registered, so they lag a register write
      hold <= cfg_wr;
      if (accept) begin
        mode  <= mode_next;
        prev  <= samples.last ? '0 : samples.sample;
        index <= samples.last ? '0 : index_inc;
      end
    end
  end

endmodule

// File: rtl/rftm_back.sv
// Back end: crossing interpolation, accumulation and frame results.
`timescale 1ns / 1ps
module rftm_back (
  input  logic           clk,
  input  logic           rst,
  input  rftm_pkg::cfg_t cfg,
  input  logic           empty,
  input  rftm_pkg::job_t pop_job,
  output logic           pop,
  rftm_result_if.source  results
);

  rftm_pkg::back_state_t state, state_next;
  rftm_pkg::job_t job;

  logic [rftm_pkg::FRAC_W:0]      frac;
  logic [rftm_pkg::DEN_W:0]       rem;
  logic [rftm_pkg::DEN_W-1:0]     dvs;
  logic [rftm_pkg::ITER_W-1:0]    iter;
  logic [rftm_pkg::POS_W-1:0]     edge_start;
  logic [rftm_pkg::TOTAL_W-1:0]   rise_total, fall_total;
  logic [rftm_pkg::COUNT_W-1:0]   rise_edges, fall_edges;
  logic [rftm_pkg::PROD_W-1:0]    prod;
  logic [rftm_pkg::CSUM_W-1:0]    csum;
  logic [rftm_pkg::CSUM_W:0]      mrem;
  logic [rftm_pkg::DIVD_W-1:0]    mdvd, mquo;
  logic                           sel;
  logic [rftm_pkg::TIME_W-1:0]    rise_ns, fall_ns;
  logic [rftm_pkg::STATUS_W-1:0]  status;

  logic                           cond, num_neg, den_neg;
  logic [rftm_pkg::NUM_W-1:0]     nmag;
  logic [rftm_pkg::DEN_W-1:0]     dmag;
  logic [rftm_pkg::DEN_W:0]       rem2;
  logic [rftm_pkg::POS_W-1:0]     pos, diff;
  logic [rftm_pkg::TOTAL_W:0]     sum;
  logic [rftm_pkg::TOTAL_W-1:0]   tot_sel, sum_sat;
  logic [rftm_pkg::COUNT_W-1:0]   cnt_sel;
  logic [rftm_pkg::CSUM_W:0]      mrem2;
  logic [rftm_pkg::TIME_W-1:0]    mean;
  logic                           cfg_ok;
  logic [rftm_pkg::HALF_W-1:0]    half;
  logic [rftm_pkg::HALF_W+rftm_pkg::NS_W-1:0] part;
  logic [rftm_pkg::CSUM_W-1:0]    csum_next;

  assign num_neg = job.num[rftm_pkg::NUM_W-1];
  assign den_neg = job.den[rftm_pkg::DEN_W-1];
  assign cond = (job.den != '0) && (job.num != '0) && (num_neg == den_neg);
  assign nmag = num_neg ? rftm_pkg::NUM_W'(-job.num) : rftm_pkg::NUM_W'(job.num);
  assign dmag = den_neg ? rftm_pkg::DEN_W'(-job.den) : rftm_pkg::DEN_W'(job.den);
  assign rem2 = {rem[rftm_pkg::DEN_W-1:0], 1'b0};

  assign pos  = {1'b0, job.idx, {rftm_pkg::FRAC_W{1'b0}}} + rftm_pkg::POS_W'(frac);
  assign diff = pos - edge_start;
  assign tot_sel = (job.ev == rftm_pkg::EV_CLOSE_RISE) ? rise_total : fall_total;
  assign sum = {1'b0, tot_sel} + (rftm_pkg::TOTAL_W + 1)'(diff);
  assign sum_sat = sum[rftm_pkg::TOTAL_W] ? '1 : sum[rftm_pkg::TOTAL_W-1:0];

  assign cnt_sel = sel ? fall_edges : rise_edges;
  assign mrem2 = {mrem[rftm_pkg::CSUM_W-1:0], mdvd[rftm_pkg::DIVD_W-1]};
  assign mean = (cnt_sel == '0) ? '0 :
                (mquo[rftm_pkg::DIVD_W-1:rftm_pkg::TIME_W] != '0) ? '1 :
                mquo[rftm_pkg::TIME_W-1:0];

  // one 20x30 multiplier, low half of the total first, then the high half
  assign half = (state == rftm_pkg::B_MHI)
              ? (sel ? fall_total[rftm_pkg::TOTAL_W-1:rftm_pkg::HALF_W]
                     : rise_total[rftm_pkg::TOTAL_W-1:rftm_pkg::HALF_W])
              : (sel ? fall_total[rftm_pkg::HALF_W-1:0] : rise_total[rftm_pkg::HALF_W-1:0]);
  assign part = half * rftm_pkg::NS_SCALE;
  assign csum_next = cnt_sel * cfg.rate;

  assign cfg_ok = job.enough && (cfg.rate != '0) &&
                  ($signed(cfg.high_level) > $signed(cfg.low_level)) &&
                  (cfg.hi_frac <= rftm_pkg::ONE_RATIO) &&
                  (cfg.hi_frac > cfg.lo_frac);

  always_comb begin
    state_next = state;
    pop = 1'b0;
    results.valid = 1'b0;
    unique case (state)
      rftm_pkg::B_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (pop_job.ev != rftm_pkg::EV_NONE) state_next = rftm_pkg::B_PREP;
          else state_next = rftm_pkg::B_END;
        end
      end
      rftm_pkg::B_PREP: begin
        if (cond && nmag < rftm_pkg::NUM_W'(dmag)) state_next = rftm_pkg::B_FRAC;
        else state_next = rftm_pkg::B_APPLY;
      end
      rftm_pkg::B_FRAC: begin
        if (iter == rftm_pkg::ITER_W'(rftm_pkg::FRAC_W - 1)) state_next = rftm_pkg::B_APPLY;
      end
      rftm_pkg::B_APPLY: state_next = job.last ? rftm_pkg::B_END : rftm_pkg::B_IDLE;
      rftm_pkg::B_END:   state_next = cfg_ok ? rftm_pkg::B_MLO : rftm_pkg::B_OUT;
      rftm_pkg::B_MLO:   state_next = rftm_pkg::B_MHI;
      rftm_pkg::B_MHI:   state_next = rftm_pkg::B_MINIT;
      rftm_pkg::B_MINIT: state_next = rftm_pkg::B_MDIV;
      rftm_pkg::B_MDIV: begin
        if (iter == rftm_pkg::ITER_W'(rftm_pkg::DIVD_W - 1)) state_next = rftm_pkg::B_MDONE;
      end
      rftm_pkg::B_MDONE: state_next = sel ? rftm_pkg::B_OUT : rftm_pkg::B_MLO;
      rftm_pkg::B_OUT: begin
        results.valid = 1'b1;
        if (results.ready) state_next = rftm_pkg::B_IDLE;
      end
      default: state_next = rftm_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rftm_pkg::B_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_start <= '0;
      rise_total <= '0;
      fall_total <= '0;
      rise_edges <= '0;
      fall_edges <= '0;
    end else begin
      unique case (state)
        rftm_pkg::B_IDLE: begin
          if (!empty) job <= pop_job;
        end
        rftm_pkg::B_PREP: begin
          iter <= '0;
          rem  <= {1'b0, rftm_pkg::DEN_W'(nmag)};
          dvs  <= dmag;
          if (!cond) frac <= '0;
          else if (nmag >= rftm_pkg::NUM_W'(dmag)) frac <= rftm_pkg::ONE_FRAC;
          else frac <= '0;
        end
        rftm_pkg::B_FRAC: begin
          iter <= iter + 1'b1;
          if (rem2 >= {1'b0, dvs}) begin
            rem  <= rem2 - {1'b0, dvs};
            frac <= {frac[rftm_pkg::FRAC_W-1:0], 1'b1};
          end else begin
            rem  <= rem2;
            frac <= {frac[rftm_pkg::FRAC_W-1:0], 1'b0};
          end
        end
        rftm_pkg::B_APPLY: begin
          unique case (job.ev)
            rftm_pkg::EV_OPEN_RISE, rftm_pkg::EV_OPEN_FALL: edge_start <= pos;
            rftm_pkg::EV_CLOSE_RISE: begin
              if (pos > edge_start) begin
                rise_total <= sum_sat;
                if (rise_edges != '1) rise_edges <= rise_edges + 1'b1;
              end
            end
            rftm_pkg::EV_CLOSE_FALL: begin
              if (pos > edge_start) begin
                fall_total <= sum_sat;
                if (fall_edges != '1) fall_edges <= fall_edges + 1'b1;
              end
            end
            default: ;
          endcase
        end
        rftm_pkg::B_END: begin
          sel <= 1'b0;
          rise_ns <= '0;
          fall_ns <= '0;
          if (!cfg_ok) status <= rftm_pkg::STATUS_INVALID;
          else if (rise_edges == '0 && fall_edges == '0) status <= rftm_pkg::STATUS_NO_EDGES;
          else status <= rftm_pkg::STATUS_OK;
        end
        rftm_pkg::B_MLO: begin
          prod <= rftm_pkg::PROD_W'(part);
        end
        rftm_pkg::B_MHI: begin
          prod <= prod + (rftm_pkg::PROD_W'(part) << rftm_pkg::HALF_W);
          csum <= csum_next;
        end
        rftm_pkg::B_MINIT: begin
          mdvd <= prod[rftm_pkg::PROD_W-1:rftm_pkg::FRAC_W];
          mrem <= '0;
          mquo <= '0;
          iter <= '0;
        end
        rftm_pkg::B_MDIV: begin
          iter <= iter + 1'b1;
          mdvd <= {mdvd[rftm_pkg::DIVD_W-2:0], 1'b0};
          if (mrem2 >= {1'b0, csum}) begin
            mrem <= mrem2 - {1'b0, csum};
            mquo <= {mquo[rftm_pkg::DIVD_W-2:0], 1'b1};
          end else begin
            mrem <= mrem2;
            mquo <= {mquo[rftm_pkg::DIVD_W-2:0], 1'b0};
          end
        end
        rftm_pkg::B_MDONE: begin
          if (sel) fall_ns <= mean;
          else rise_ns <= mean;
          sel <= 1'b1;
        end
        rftm_pkg::B_OUT: begin
          if (results.ready) begin
            edge_start <= '0;
            rise_total <= '0;
            fall_total <= '0;
            rise_edges <= '0;
            fall_edges <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign results.status       = status;
  assign results.rise_time_ns = rise_ns;
  assign results.fall_time_ns = fall_ns;
  assign results.rise_num     = (status == rftm_pkg::STATUS_INVALID) ? '0 : rise_edges;
  assign results.fall_num     = (status == rftm_pkg::STATUS_INVALID) ? '0 : fall_edges;

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && status == rftm_pkg::STATUS_INVALID |->
    rise_ns == '0 && fall_ns == '0)
    else $error("invalid result carries nonzero times");
  a_no_edges_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && status == rftm_pkg::STATUS_NO_EDGES |->
    rise_ns == '0 && fall_ns == '0 && rise_edges == '0 && fall_edges == '0)
    else $error("no-edge result carries edge data");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == rftm_pkg::B_IDLE)
    else $error("request popped while back end busy");
  a_cleared_after_out: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.ready |=> rise_edges == '0 && fall_edges == '0)
    else $error("frame state not cleared after result");

endmodule
